/* rtl/core/b91se_pkg.sv */
// shared types, constants and helper functions of the base91 stream encoder
package b91se_pkg;

  localparam int unsigned QueueBits = 13;
  localparam int unsigned HeldBits  = 4;

  localparam logic [12:0] Low13Limit = 13'd88;
  localparam logic [12:0] FlushLimit = 13'd90;
  localparam logic [3:0]  FlushHigh  = 4'd7;
  localparam logic [4:0]  SplitLimit = 5'd13;
  localparam logic [7:0]  Radix      = 8'd91;
  localparam logic [7:0]  GapIndex   = 8'd59;
  localparam logic [27:0] RecipMul   = 28'd11523;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [6:0] code_char;
    logic       final_char;
  } out_item_t;

  typedef struct packed {
    logic [13:0] v_ext;
    logic [7:0]  q_ext;
    logic [12:0] v_fl;
    logic [7:0]  q_fl;
    logic        has_ext;
    logic [1:0]  n_fl;
    logic        last;
  } split_t;

  // exact quotient by 91 for any 14-bit value
  function automatic logic [7:0] div91(input logic [13:0] v);
    logic [27:0] p;
    p = 28'(v) * RecipMul;
    return p[27:20];
  endfunction

  // base91 alphabet: '!' upward, backslash skipped
  function automatic logic [6:0] b91_char(input logic [7:0] idx);
    logic [7:0] i;
    logic [7:0] c;
    i = (idx >= Radix) ? idx - Radix : idx;
    c = (i < GapIndex) ? i + 8'd33 : i + 8'd34;
    return c[6:0];
  endfunction

endpackage

/* rtl/core/b91se_split.sv */
// bit queue state, value extraction and flush, quotient stage register
module b91se_split (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  b91se_pkg::in_item_t item,
  output logic              item_stall,
  output logic              grp_valid,
  output b91se_pkg::split_t grp,
  input  logic              grp_stall
);
  import b91se_pkg::*;

  logic [QueueBits-1:0] queue;
  logic [HeldBits-1:0]  held;

  logic [20:0] q_full;
  logic [4:0]  held_sum;
  logic        ext;
  logic        take13;
  logic [13:0] v_ext;
  logic [20:0] shifted;
  logic [4:0]  rem_held5;
  logic [12:0] rq;
  logic [3:0]  rh;
  logic [1:0]  n_fl;
  logic        adv;
  split_t      grp_next;

  always_comb begin
    q_full   = 21'(queue) | (21'(item.data_byte) << held);
    held_sum = 5'(held) + 5'd8;
    ext      = held_sum > SplitLimit;
    take13   = q_full[12:0] > Low13Limit;
    v_ext    = take13 ? {1'b0, q_full[12:0]} : q_full[13:0];
    shifted  = take13 ? (q_full >> 13) : (q_full >> 14);
    rem_held5 = take13 ? held_sum - 5'd13 : held_sum - 5'd14;
    rq       = ext ? shifted[12:0] : q_full[12:0];
    rh       = ext ? rem_held5[3:0] : held_sum[3:0];
    if (!item.end_of_message || rh == '0) begin
      n_fl = 2'd0;
    end else if (rh > FlushHigh || rq > FlushLimit) begin
      n_fl = 2'd2;
    end else begin
      n_fl = 2'd1;
    end
    grp_next.v_ext   = v_ext;
    grp_next.q_ext   = div91(v_ext);
    grp_next.v_fl    = rq;
    grp_next.q_fl    = div91({1'b0, rq});
    grp_next.has_ext = ext;
    grp_next.n_fl    = n_fl;
    grp_next.last    = item.end_of_message;
  end

  assign adv        = item_valid && (!grp_valid || !grp_stall);
  assign item_stall = item_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue     <= '0;
      held      <= '0;
      grp_valid <= 1'b0;
    end else if (adv) begin
      queue     <= item.end_of_message ? '0 : rq;
      held      <= item.end_of_message ? '0 : rh;
      grp_valid <= 1'b1;
    end else if (!grp_stall) begin
      grp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grp <= grp_next;
    end
  end

endmodule

/* rtl/core/b91se_emit.sv */
// remainders, alphabet lookup and character buffer that drives the output
module b91se_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              grp_valid,
  input  b91se_pkg::split_t grp,
  output logic              grp_stall,
  output logic              char_valid,
  output b91se_pkg::out_item_t char_item,
  input  logic              char_stall
);
  import b91se_pkg::*;

  logic [6:0] slot_char [4];
  logic       slot_final [4];
  logic [2:0] cnt;

  logic [13:0] r_ext;
  logic [12:0] r_fl;
  logic [6:0]  c [4];
  logic [6:0]  new_char [4];
  logic        new_final [4];
  logic [2:0]  n;
  logic        out_acc;
  logic        em_free;
  logic        take;
  logic        load;

  always_comb begin
    r_ext = grp.v_ext - 14'(grp.q_ext) * 14'd91;
    r_fl  = grp.v_fl - 13'(grp.q_fl) * 13'd91;
    c[0]  = b91_char({1'b0, r_ext[6:0]});
    c[1]  = b91_char(grp.q_ext);
    c[2]  = b91_char({1'b0, r_fl[6:0]});
    c[3]  = b91_char(grp.q_fl);
    n     = (grp.has_ext ? 3'd2 : 3'd0) + 3'(grp.n_fl);
    if (grp.has_ext) begin
      new_char[0] = c[0];
      new_char[1] = c[1];
      new_char[2] = c[2];
      new_char[3] = c[3];
    end else begin
      new_char[0] = c[2];
      new_char[1] = c[3];
      new_char[2] = c[2];
      new_char[3] = c[3];
    end
    for (int i = 0; i < 4; i++) begin
      new_final[i] = grp.last && (3'(i) == n - 3'd1);
    end
  end

  assign out_acc   = char_valid && !char_stall;
  assign em_free   = (cnt == 3'd0) || (cnt == 3'd1 && out_acc);
  assign take      = grp_valid && (n == 3'd0 || em_free);
  assign load      = take && n != 3'd0;
  assign grp_stall = grp_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= n;
    end else if (out_acc) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 4; i++) begin
        slot_char[i]  <= new_char[i];
        slot_final[i] <= new_final[i];
      end
    end else if (out_acc) begin
      for (int i = 0; i < 3; i++) begin
        slot_char[i]  <= slot_char[i+1];
        slot_final[i] <= slot_final[i+1];
      end
    end
  end

  assign char_valid           = cnt != 3'd0;
  assign char_item.code_char  = slot_char[0];
  assign char_item.final_char = slot_final[0];

endmodule

/* rtl/core/base91_stream_encoder.sv */
// top level of the base91 stream encoder
//
//   channel   direction  payload      handshake
//   byte_*    in         in_item_t    byte_valid / byte_stall
//   char_*    out        out_item_t   char_valid / char_stall
//
// a byte enters an input register, then the split stage updates the bit queue
// and divides by 91 into the split register, then the emit stage buffers up to four chars
// a byte's first char is valid from the char buffer after the input and split registers
// one char leaves per cycle while char_stall is low; new chars load as the last one leaves
// rst is synchronous and clears the bit queue and all valid flags
// char_stall backs up through the buffers into byte_stall
module base91_stream_encoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  b91se_pkg::in_item_t   byte_item,
  output logic                  char_valid,
  input  logic                  char_stall,
  output b91se_pkg::out_item_t  char_item
);
  import b91se_pkg::*;

  logic     s1_valid;
  in_item_t s1_item;
  logic     s1_stall;
  logic     grp_valid;
  split_t   grp;
  logic     grp_stall;
  logic     byte_acc;

  assign byte_stall = s1_valid && s1_stall;
  assign byte_acc   = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_acc) begin
      s1_valid <= 1'b1;
    end else if (!s1_stall) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_acc) begin
      s1_item <= byte_item;
    end
  end

  b91se_split u_split (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s1_valid),
    .item       (s1_item),
    .item_stall (s1_stall),
    .grp_valid  (grp_valid),
    .grp        (grp),
    .grp_stall  (grp_stall)
  );

  b91se_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .grp_valid  (grp_valid),
    .grp        (grp),
    .grp_stall  (grp_stall),
    .char_valid (char_valid),
    .char_item  (char_item),
    .char_stall (char_stall)
  );

endmodule

/* rtl/core/b91se_check.sv */
// port checker for the base91 stream encoder and its bind
module b91se_check (
  input logic                 clk,
  input logic                 rst,
  input logic                 byte_valid,
  input logic                 byte_stall,
  input b91se_pkg::in_item_t  byte_item,
  input logic                 char_valid,
  input logic                 char_stall,
  input b91se_pkg::out_item_t char_item
);
  import b91se_pkg::*;

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !char_valid && !byte_stall)
    else $error("outputs not idle after reset");

  a_char_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_stall |=> char_valid && $stable(char_item))
    else $error("stalled char transaction changed");

  a_byte_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(byte_item))
    else $error("stalled byte transaction changed");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> char_item.code_char >= 7'd33 && char_item.code_char <= 7'd124
                   && char_item.code_char != 7'd92)
    else $error("char outside base91 alphabet");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    byte_stall && !$past(rst) |-> $past(byte_valid) || $past(byte_stall))
    else $error("byte stall without a held transaction");

endmodule

bind base91_stream_encoder b91se_check u_check (.*);

/* bench/tb.sv */
// testbench for the base91 stream encoder: queued byte driver, char monitor, predictor
`timescale 1ns / 1ps

module tb;
  import b91se_pkg::*;

  typedef struct {
    in_item_t    item;
    int unsigned gap;
  } byte_slot_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  in_item_t   byte_item = '0;
  logic       char_valid;
  logic       char_stall = 1'b0;
  out_item_t  char_item;

  byte_slot_t  byte_plan[$];
  out_item_t   pending_chars[$];
  logic [20:0] bit_store = '0;
  logic [4:0]  bits_in_store = '0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  bit          rx_lazy = 1'b1;
  bit          choke = 1'b0;
  int          phase = 0;
  int          bad = 0;

  base91_stream_encoder DUT (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void emit_char(int unsigned idx);
    out_item_t c;
    idx = idx % 91;
    c.code_char = (idx < 59) ? 7'(33 + idx) : 7'(34 + idx);
    c.final_char = 1'b0;
    pending_chars.push_back(c);
  endfunction

  function automatic void encode_byte(in_item_t b);
    int unsigned first;
    int unsigned v;
    first = pending_chars.size();
    bit_store = bit_store | (21'(b.data_byte) << bits_in_store);
    bits_in_store = bits_in_store + 5'd8;
    if (bits_in_store > 5'd13) begin
      if (bit_store[12:0] > 13'd88) begin
        v = 32'(bit_store[12:0]);
        bit_store = bit_store >> 13;
        bits_in_store = bits_in_store - 5'd13;
      end else begin
        v = 32'(bit_store[13:0]);
        bit_store = bit_store >> 14;
        bits_in_store = bits_in_store - 5'd14;
      end
      emit_char(v % 91);
      emit_char(v / 91);
    end
    if (b.end_of_message) begin
      if (bits_in_store > 5'd0) begin
        emit_char(bit_store % 91);
        if (bits_in_store > 5'd7 || bit_store > 21'd90) begin
          emit_char(bit_store / 91);
        end
      end
      if (pending_chars.size() > first) begin
        pending_chars[pending_chars.size() - 1].final_char = 1'b1;
      end
      bit_store = '0;
      bits_in_store = '0;
    end
  endfunction

  task automatic put_byte(logic [7:0] b, bit last, bit quick);
    byte_slot_t s;
    s.item.data_byte = b;
    s.item.end_of_message = last;
    s.gap = quick ? 0 : $urandom_range(0, 19);
    byte_plan.push_back(s);
  endtask

  task automatic add_message(int len, bit quick);
    int r;
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      if (r < 6) b = 8'($urandom_range(0, 255));
      else if (r < 9) b = 8'($urandom_range(0, 15));
      else b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      put_byte(b, i == len - 1, quick);
    end
  endtask

  task automatic wait_drained();
    while (byte_plan.size() > 0 || byte_valid || pending_chars.size() > 0) @(posedge clk);
  endtask

  // byte driver
  always @(posedge clk) begin
    byte_slot_t nxt;
    if (rst) begin
      byte_valid <= 1'b0;
      tx_wait <= 0;
    end else begin
      if (byte_valid && !byte_stall) encode_byte(byte_item);
      if (!byte_valid || !byte_stall) begin
        if (tx_wait > 0) begin
          tx_wait <= tx_wait - 1;
          byte_valid <= 1'b0;
        end else if (byte_plan.size() > 0) begin
          nxt = byte_plan.pop_front();
          byte_item <= nxt.item;
          byte_valid <= 1'b1;
          tx_wait <= nxt.gap;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // char monitor and receiver stall
  always @(posedge clk) begin
    int unsigned d;
    out_item_t want;
    if (rst) begin
      char_stall <= 1'b0;
      rx_wait <= 0;
    end else begin
      d = rx_wait;
      if (char_valid && !char_stall) begin
        if (pending_chars.size() == 0) begin
          bad++;
          if (bad <= 10) $display("unexpected char: code %0d final %0b",
                                  char_item.code_char, char_item.final_char);
        end else begin
          want = pending_chars.pop_front();
          if (char_item.code_char !== want.code_char
              || char_item.final_char !== want.final_char) begin
            bad++;
            if (bad <= 10)
              $display("char mismatch: expected code %0d final %0b, got code %0d final %0b",
                       want.code_char, want.final_char,
                       char_item.code_char, char_item.final_char);
          end
        end
        d = rx_lazy ? $urandom_range(0, 19) : 0;
        if ($urandom_range(0, 39) == 0) rx_lazy <= !rx_lazy;
      end else if (d > 0) begin
        d = d - 1;
      end
      rx_wait <= d;
      char_stall <= (d > 0) || choke;
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (phase == 2);
    @(posedge clk);
    choke <= 1'b1;
    repeat (400) @(posedge clk);
    choke <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    int n;
    int len;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    phase = 1;

    put_byte(8'h00, 1'b1, 1'b0);
    put_byte(8'hFF, 1'b1, 1'b0);
    for (int i = 0; i < 7; i++) put_byte(8'h00, i == 6, 1'b0);
    for (int i = 0; i < 3; i++) put_byte(8'hFF, i == 2, 1'b1);
    put_byte(8'h5A, 1'b0, 1'b0);
    put_byte(8'hA5, 1'b1, 1'b0);
    put_byte(8'h00, 1'b0, 1'b1);
    put_byte(8'h00, 1'b1, 1'b1);
    put_byte(8'h7F, 1'b0, 1'b0);
    put_byte(8'h80, 1'b1, 1'b0);
    wait_drained();

    phase = 2;
    n = 0;
    while (n < 60) begin
      len = $urandom_range(1, 12);
      add_message(len, 1'b1);
      n += len;
    end
    wait_drained();

    phase = 3;
    n = 0;
    while (n < 340) begin
      len = $urandom_range(1, 16);
      add_message(len, $urandom_range(0, 3) == 0);
      n += len;
    end
    while (byte_plan.size() > 0 || byte_valid) @(posedge clk);
    for (int k = 0; k < 5000 && pending_chars.size() > 0; k++) @(posedge clk);
    repeat (10) @(posedge clk);

    if (bad == 0 && pending_chars.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/b91se_pkg.sv
rtl/core/b91se_split.sv
rtl/core/b91se_emit.sv
rtl/core/base91_stream_encoder.sv
rtl/core/b91se_check.sv
bench/tb.sv
